// ----- hw/rtl/sawarq_pkg.sv -----
// Package for the stop-and-wait ARQ link unit.
// Holds field widths, item and result codes, register indexes and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package sawarq_pkg;

    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int TIMEOUT_W = 8;

    // item kinds (input mode field)
    localparam logic [MODE_W-1:0] MODE_PACKET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOST   = 2'd2;

    // received packet types
    localparam logic [BYTE_W-1:0] TYPE_DATA = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_ACK  = 8'h00;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd2;

    // configuration registers
    localparam int ADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_ECHO    = 1'b1;
    localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = 8'd20;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] seq;
        logic [BYTE_W-1:0] payload;
        logic              last;
    } t_result;

endpackage

// ----- hw/rtl/sawarq_in_if.sv -----
// Input channel of the stop-and-wait ARQ link unit: valid/ready plus item fields.
// Depends on sawarq_pkg for field widths.
`timescale 1ns / 1ps

interface sawarq_in_if;
    logic                             valid;
    logic                             ready;
    logic [sawarq_pkg::MODE_W-1:0]    mode;
    logic [sawarq_pkg::BYTE_W-1:0]    packet_type;
    logic [sawarq_pkg::BYTE_W-1:0]    packet_seq;
    logic [sawarq_pkg::BYTE_W-1:0]    packet_byte;
    logic [sawarq_pkg::BYTE_W-1:0]    host_byte;

    modport source (output valid, output mode, output packet_type, output packet_seq,
                    output packet_byte, output host_byte, input ready);
    modport sink   (input valid, input mode, input packet_type, input packet_seq,
                    input packet_byte, input host_byte, output ready);
endinterface

// ----- hw/rtl/sawarq_out_if.sv -----
// Output channel of the stop-and-wait ARQ link unit: valid/ready plus result fields.
// Depends on sawarq_pkg for field widths.
`timescale 1ns / 1ps

interface sawarq_out_if;
    logic                             valid;
    logic                             ready;
    logic [sawarq_pkg::KIND_W-1:0]    kind;
    logic [sawarq_pkg::BYTE_W-1:0]    seq;
    logic [sawarq_pkg::BYTE_W-1:0]    payload;
    logic                             last;

    modport source (output valid, output kind, output seq, output payload, output last,
                    input ready);
    modport sink   (input valid, input kind, input seq, input payload, input last,
                    output ready);
endinterface

// ----- hw/rtl/stop_and_wait_arq_link_unit.sv -----
// Stop-and-wait ARQ link endpoint: protocol state, APB register block, result queue.
// Depends on sawarq_pkg, sawarq_in_if and sawarq_out_if.
//
// Channel   Dir  Handshake           Word
// i_in      in   valid/ready         mode, packet_type, packet_seq, packet_byte, host_byte
// o_out     out  valid/ready         kind, seq, payload, last
// APB       in   psel/penable/pwrite timeout_ticks @0x0, echo_mode @0x4
//
// One input word is taken per cycle whenever the result queue has room for two words;
// the protocol state updates at that same edge and its results land in the queue.
// The output gives one word per cycle while o_out.ready holds, so a stream of items that each raise
// two results is paced by the output side rather than by the input side.
// i_rst_n is synchronous, active low: all protocol state clears, timeout returns to 20.
// A stalled output only holds o_out and, once the queue is nearly full, drops i_in.ready.
`timescale 1ns / 1ps

module stop_and_wait_arq_link_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sawarq_in_if.sink                          i_in,
    sawarq_out_if.source                       o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sawarq_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [sawarq_pkg::TIMEOUT_W-1:0] r_timeout;
    logic                             r_echo;
    logic                             cfg_wr;
    logic                             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= sawarq_pkg::RESET_TIMEOUT;
            r_echo    <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sawarq_pkg::REG_TIMEOUT: r_timeout <= pwdata[sawarq_pkg::TIMEOUT_W-1:0];
                sawarq_pkg::REG_ECHO:    r_echo    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sawarq_pkg::REG_TIMEOUT: prdata = {24'd0, r_timeout};
            sawarq_pkg::REG_ECHO:    prdata = {31'd0, r_echo};
            default:                 prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Protocol state
    // ---------------------------------------------------------------
    logic [7:0] r_sent_seq,  n_sent_seq;
    logic [7:0] r_acked_seq, n_acked_seq;
    logic [7:0] r_recv_seq,  n_recv_seq;
    logic       r_ack_due,   n_ack_due;
    logic [7:0] r_ticks,     n_ticks;
    logic [7:0] r_sent_byte, n_sent_byte;
    logic [7:0] r_pending,   n_pending;

    // result queue
    sawarq_pkg::t_result              r_q [sawarq_pkg::Q_DEPTH];
    logic [sawarq_pkg::Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [sawarq_pkg::Q_CNT_W-1:0]   r_count;

    logic                 in_acc;
    logic                 out_acc;
    sawarq_pkg::t_result  res0, res1;
    logic [1:0]           n_res;

    // limits and tick bookkeeping
    logic [7:0] limit;
    logic       send_new;
    logic [7:0] ticks_a, ticks_b;
    logic       resend;
    logic [1:0] n_before;

    // Take a word only while two queue slots are free, whatever the output does.
    assign i_in.ready = (r_count <= sawarq_pkg::Q_CNT_W'(sawarq_pkg::Q_DEPTH - 2));
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    always_comb begin
        n_sent_seq  = r_sent_seq;
        n_acked_seq = r_acked_seq;
        n_recv_seq  = r_recv_seq;
        n_ack_due   = r_ack_due;
        n_ticks     = r_ticks;
        n_sent_byte = r_sent_byte;
        n_pending   = r_pending;
        res0        = '0;
        res1        = '0;
        n_res       = 2'd0;
        n_before    = 2'd0;
        limit       = (r_timeout != 8'd0) ? r_timeout : 8'd1;
        send_new    = (r_acked_seq == r_sent_seq) && (r_pending != 8'd0);
        ticks_a     = send_new ? 8'd0 : r_ticks;
        ticks_b     = (ticks_a != 8'hFF) ? ticks_a + 8'd1 : ticks_a;
        resend      = 1'b0;

        case (i_in.mode)
            sawarq_pkg::MODE_PACKET: begin
                if (i_in.packet_type == sawarq_pkg::TYPE_DATA) begin
                    // deliver only a fresh sequence number; always owe an ack
                    if (i_in.packet_seq != r_recv_seq) begin
                        n_recv_seq = i_in.packet_seq;
                        res0  = '{kind: sawarq_pkg::KIND_DELIVER, seq: i_in.packet_seq,
                                  payload: i_in.packet_byte, last: 1'b1};
                        n_res = 2'd1;
                        if (r_echo) begin
                            n_pending = i_in.packet_byte;
                        end
                    end
                    n_ack_due = 1'b1;
                end else if (i_in.packet_type == sawarq_pkg::TYPE_ACK) begin
                    n_acked_seq = i_in.packet_seq;
                end
            end
            sawarq_pkg::MODE_TICK: begin
                // new data first, then a due ack, then a timed-out resend
                if (send_new) begin
                    n_sent_byte = r_pending;
                    n_pending   = 8'd0;
                    n_sent_seq  = r_sent_seq + 8'd1;
                    res0 = '{kind: sawarq_pkg::KIND_DATA, seq: r_sent_seq + 8'd1,
                             payload: r_pending, last: 1'b0};
                    n_before = 2'd1;
                end
                if ((r_recv_seq != 8'd0) && r_ack_due) begin
                    if (n_before == 2'd0) begin
                        res0 = '{kind: sawarq_pkg::KIND_ACK, seq: r_recv_seq,
                                 payload: 8'd0, last: 1'b0};
                    end else begin
                        res1 = '{kind: sawarq_pkg::KIND_ACK, seq: r_recv_seq,
                                 payload: 8'd0, last: 1'b0};
                    end
                    n_before  = n_before + 2'd1;
                    n_ack_due = 1'b0;
                end
                n_ticks = ticks_b;
                resend  = (r_acked_seq != n_sent_seq) && (ticks_b > limit)
                          && (n_before != 2'd2);
                if (resend) begin
                    if (n_before == 2'd0) begin
                        res0 = '{kind: sawarq_pkg::KIND_DATA, seq: n_sent_seq,
                                 payload: n_sent_byte, last: 1'b0};
                    end else begin
                        res1 = '{kind: sawarq_pkg::KIND_DATA, seq: n_sent_seq,
                                 payload: n_sent_byte, last: 1'b0};
                    end
                    n_ticks = 8'd0;
                end
                n_res = n_before + {1'b0, resend};
                // mark the final word of this item
                if (n_res == 2'd1) begin
                    res0.last = 1'b1;
                end
                if (n_res == 2'd2) begin
                    res1.last = 1'b1;
                end
            end
            sawarq_pkg::MODE_HOST: begin
                if (i_in.host_byte != 8'd0) begin
                    n_pending = i_in.host_byte;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_seq  <= 8'd0;
            r_acked_seq <= 8'd0;
            r_recv_seq  <= 8'd0;
            r_ack_due   <= 1'b0;
            r_ticks     <= 8'd0;
            r_sent_byte <= 8'd0;
            r_pending   <= 8'd0;
        end else if (in_acc) begin
            r_sent_seq  <= n_sent_seq;
            r_acked_seq <= n_acked_seq;
            r_recv_seq  <= n_recv_seq;
            r_ack_due   <= n_ack_due;
            r_ticks     <= n_ticks;
            r_sent_byte <= n_sent_byte;
            r_pending   <= n_pending;
        end
    end

    // ---------------------------------------------------------------
    // Result queue: push up to two words, pop one
    // ---------------------------------------------------------------
    logic [1:0] push_n;
    assign push_n = in_acc ? n_res : 2'd0;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr_ptr + sawarq_pkg::Q_PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + sawarq_pkg::Q_PTR_W'(push_n);
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + sawarq_pkg::Q_PTR_W'(1);
            end
            r_count <= r_count + sawarq_pkg::Q_CNT_W'(push_n)
                       - sawarq_pkg::Q_CNT_W'(out_acc);
        end
    end

    assign o_out.valid   = (r_count != '0);
    assign o_out.kind    = r_q[r_rd_ptr].kind;
    assign o_out.seq     = r_q[r_rd_ptr].seq;
    assign o_out.payload = r_q[r_rd_ptr].payload;
    assign o_out.last    = r_q[r_rd_ptr].last;

`ifndef SYNTHESIS
    // queue never overfills
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sawarq_pkg::Q_CNT_W'(sawarq_pkg::Q_DEPTH))
        else $error("result queue overflow");

    // a tick with a received sequence number leaves no ack owed
    a_ack_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.mode == sawarq_pkg::MODE_TICK) && (r_recv_seq != 8'd0))
        |=> !r_ack_due)
        else $error("ack still due after tick");

    // the send sequence number only ever advances by one
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_sent_seq))
        |-> (r_sent_seq == 8'($past(r_sent_seq) + 8'd1)))
        else $error("send sequence jumped");

    // a word pushed into an empty queue is offered on the next cycle
    a_push_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (n_res != 2'd0)) |=> o_out.valid)
        else $error("pushed result not offered");
`endif

endmodule
